>>> sv/ws_fe_pkg.sv
// shared types, constants and the bit encoder for the ws2812 frame encoder
`default_nettype none

package ws_fe_pkg;

  localparam int LED_MAX     = 1024;
  localparam int RESET_WORDS = 8;

  localparam int LED_AW = $clog2(LED_MAX);
  localparam int CNT_W  = $clog2(LED_MAX + 1);
  localparam int POS_W  = 12;
  localparam int PIX_W  = 24;
  localparam int WORD_W = 64;

  localparam logic [7:0] BIT_ONE  = 8'hF8;
  localparam logic [7:0] BIT_ZERO = 8'hC0;

  // request types
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_PULL  = 2'd2;

  // word slot within one led
  localparam logic [1:0] SUB_G = 2'd0;
  localparam logic [1:0] SUB_R = 2'd1;
  localparam logic [1:0] SUB_B = 2'd2;

  // register indexes
  localparam logic CFG_ACTIVE_LEDS = 1'b0;
  localparam logic CFG_BRIGHTNESS  = 1'b1;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [LED_AW-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

  function automatic logic [WORD_W-1:0] spi_expand(input logic [7:0] b);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[i*8 +: 8] = b[i] ? BIT_ONE : BIT_ZERO;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/ws_fe_if.sv
// request and word channel interfaces
`default_nettype none

interface ws_fe_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [9:0] pixel_index;
  logic [23:0] rgb_color;

  modport source (output valid, req_type, pixel_index, rgb_color, input ready);
  modport sink (input valid, req_type, pixel_index, rgb_color, output ready);
endinterface

interface ws_fe_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] spi_word;
  logic        frame_last;

  modport source (output valid, spi_word, frame_last, input ready);
  modport sink (input valid, spi_word, frame_last, output ready);
endinterface

`default_nettype wire

>>> sv/ws_fe_ram.sv
// generic single-port ram with registered read
`default_nettype none

module ws_fe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/ws_fe_scale.sv
// shared brightness scaler: registered (c * brightness) >> 8
`default_nettype none

module ws_fe_scale (
  input  wire logic       clk_i,
  input  wire logic [7:0] opd_i,
  input  wire logic [7:0] bri_i,
  output      logic [7:0] res_o
);

  logic [15:0] prod;
  logic [7:0]  res_q;

  assign prod  = opd_i * bri_i;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    res_q <= prod[15:8];
  end

endmodule

`default_nettype wire

>>> sv/ws_fe_ctrl.sv
// request sequencer: store clear, write, fill and frame word generation
`default_nettype none

module ws_fe_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [ws_fe_pkg::CNT_W-1:0] led_cnt_i,
  ws_fe_req_if.sink                        req_i,
  ws_fe_word_if.source                     word_o,
  output      ws_fe_pkg::mem_req_t         mem_req_o,
  input  wire logic [ws_fe_pkg::PIX_W-1:0] mem_rdata_i,
  output      logic [7:0]                  scl_opd_o,
  input  wire logic [7:0]                  scl_res_i
);

  import ws_fe_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_RD,
    S_G,
    S_R,
    S_B,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    led_q;
  logic [1:0]          sub_q;
  logic [15:0]         held_q;
  logic [PIX_W-1:0]    color_q;
  logic [WORD_W-1:0]   word_q;
  logic                last_q;
  logic                out_valid_q;
  logic [WORD_W-1:0]   out_word_q;
  logic                out_last_q;

  logic [POS_W-1:0] pix_end;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] pos_inc;
  logic             in_pix;
  logic             wrap;
  logic             accept;
  logic             out_free;

  assign pix_end  = POS_W'(RESET_WORDS) + (POS_W'(led_cnt_i) << 1) + POS_W'(led_cnt_i);
  assign total    = pix_end + POS_W'(RESET_WORDS);
  assign pos_inc  = pos_q + POS_W'(1);
  assign in_pix   = (pos_q >= POS_W'(RESET_WORDS)) && (pos_q < pix_end);
  assign wrap     = pos_inc >= total;
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || word_o.ready;

  assign req_i.ready       = (state_q == S_IDLE);
  assign word_o.valid      = out_valid_q;
  assign word_o.spi_word   = out_word_q;
  assign word_o.frame_last = out_last_q;

  // single ram port: clear sweep, fill sweep, pixel write, green-word read
  always_comb begin
    mem_req_o = '0;
    priority if (state_q == S_CLEAR) begin
      mem_req_o.we   = 1'b1;
      mem_req_o.addr = cnt_q[LED_AW-1:0];
    end else if (state_q == S_FILL) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.addr  = cnt_q[LED_AW-1:0];
      mem_req_o.wdata = color_q;
    end else if (accept && req_i.req_type == REQ_WRITE &&
                 {1'b0, req_i.pixel_index} < led_cnt_i) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.addr  = req_i.pixel_index;
      mem_req_o.wdata = req_i.rgb_color;
    end else if (accept && req_i.req_type == REQ_PULL && in_pix && sub_q == SUB_G) begin
      mem_req_o.re   = 1'b1;
      mem_req_o.addr = led_q[LED_AW-1:0];
    end else begin
      mem_req_o = '0;
    end
  end

  // scaler operand: green, then red, then blue of the pixel just read
  always_comb begin
    unique case (state_q)
      S_RD:    scl_opd_o = mem_rdata_i[15:8];
      S_G:     scl_opd_o = mem_rdata_i[23:16];
      S_R:     scl_opd_o = mem_rdata_i[7:0];
      default: scl_opd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pos_q       <= '0;
      led_q       <= '0;
      sub_q       <= SUB_G;
      held_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      color_q     <= '0;
      word_q      <= '0;
      out_word_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // a word loaded in S_EMIT takes precedence over the drain
      if (out_valid_q && word_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == CNT_W'(LED_MAX - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (req_i.req_type)
              REQ_FILL: begin
                color_q <= req_i.rgb_color;
                cnt_q   <= '0;
                if (led_cnt_i != '0) begin
                  state_q <= S_FILL;
                end
              end
              REQ_PULL: begin
                last_q <= wrap;
                pos_q  <= wrap ? '0 : pos_inc;
                if (wrap || pos_q < POS_W'(RESET_WORDS)) begin
                  led_q <= '0;
                  sub_q <= SUB_G;
                end else if (sub_q == SUB_B) begin
                  led_q <= led_q + CNT_W'(1);
                  sub_q <= SUB_G;
                end else begin
                  sub_q <= sub_q + 2'd1;
                end
                if (in_pix && sub_q == SUB_G) begin
                  state_q <= S_RD;
                end else begin
                  state_q <= S_EMIT;
                  if (!in_pix) begin
                    word_q <= '0;
                  end else if (sub_q == SUB_R) begin
                    word_q <= spi_expand(held_q[15:8]);
                  end else begin
                    word_q <= spi_expand(held_q[7:0]);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          if (cnt_q + CNT_W'(1) == led_cnt_i) begin
            state_q <= S_IDLE;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        S_RD: state_q <= S_G;
        S_G: begin
          word_q  <= spi_expand(scl_res_i);
          state_q <= S_R;
        end
        S_R: begin
          held_q[15:8] <= scl_res_i;
          state_q      <= S_B;
        end
        S_B: begin
          held_q[7:0] <= scl_res_i;
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= word_q;
            out_last_q  <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_G || state_q == S_R || state_q == S_B)
    |-> !mem_req_o.we)
    else $error("ram written during a pixel read sequence");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (cnt_q < led_cnt_i))
    else $error("fill sweep past led count");

  a_sub_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3)
    else $error("word slot out of range");

  a_wrap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == REQ_PULL && wrap) |=> (pos_q == '0 && last_q))
    else $error("frame did not wrap after last word");
`endif

endmodule

`default_nettype wire

>>> sv/ws2812_frame_encoder_top.sv
// ws2812 frame encoder top level: config registers, pixel store, scaler, sequencer
//
//  channel   dir  handshake            payload
//  req_i     in   valid/ready          req_type, pixel_index, rgb_color
//  word_o    out  valid/ready          spi_word, frame_last
//  cfg       in   cfg_we_i (no stall)  cfg_idx_i, cfg_wdata_i
//
// after reset all 1024 pixel store entries are zeroed, req_i.ready stays low meanwhile
// write and unused requests finish when accepted; fill then writes each active led
// a pull of a reset, red or blue word goes straight to S_EMIT; a green word passes
//   S_RD, S_G, S_R, S_B: one ram read and three passes through the shared 8x8 scaler
// a pull waits in its last cycle while the output register still holds an untaken word
`default_nettype none

module ws2812_frame_encoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  ws_fe_req_if.sink       req_i,
  ws_fe_word_if.source    word_o
);

  import ws_fe_pkg::*;

  logic [CNT_W-1:0] active_leds_q;
  logic [7:0]       brightness_q;
  logic [CNT_W-1:0] led_cnt;
  mem_req_t         mem_req;
  logic [PIX_W-1:0] mem_rdata;
  logic [7:0]       scl_opd;
  logic [7:0]       scl_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_leds_q <= '0;
      brightness_q  <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_LEDS: active_leds_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_BRIGHTNESS:  brightness_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // count saturates at the store depth
  assign led_cnt = (active_leds_q > CNT_W'(LED_MAX)) ? CNT_W'(LED_MAX) : active_leds_q;

  ws_fe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .led_cnt_i   (led_cnt),
    .req_i       (req_i),
    .word_o      (word_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .scl_opd_o   (scl_opd),
    .scl_res_i   (scl_res)
  );

  ws_fe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LED_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  ws_fe_scale u_scale (
    .clk_i (clk_i),
    .opd_i (scl_opd),
    .bri_i (brightness_q),
    .res_o (scl_res)
  );

endmodule

`default_nettype wire
